FILE: rtl/core/ttng_pkg.sv
// ----------------------------------------------------------------------------
// ttng_pkg: shared types and waveform tables for the tone and noise generator
// Transaction payloads, command and waveform codes, and the 64-entry waveform
// lookup used by the tone channel.
// ----------------------------------------------------------------------------
package ttng_pkg;

    localparam int TABLE_LEN = 64;
    localparam int POS_W     = $clog2(TABLE_LEN);
    localparam int SAMPLE_W  = 12;

    typedef enum logic [1:0] {
        MODE_WR0  = 2'd0,
        MODE_WR1  = 2'd1,
        MODE_TICK = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        SHAPE_SQUARE   = 2'd0,
        SHAPE_TRIANGLE = 2'd1,
        SHAPE_SINE     = 2'd2,
        SHAPE_SAW      = 2'd3
    } shape_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] data;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] tone_sample;
        logic signed [SAMPLE_W-1:0] noise_sample;
        logic                       tone_on;
        logic                       noise_on;
    } out_t;

    localparam logic [7:0] TRIANGLE_TBL [TABLE_LEN] = '{
        8'h00, 8'h07, 8'h0f, 8'h17, 8'h1f, 8'h27, 8'h2f, 8'h37,
        8'h3f, 8'h47, 8'h4f, 8'h57, 8'h5f, 8'h67, 8'h6f, 8'h77,
        8'h7f, 8'h77, 8'h6f, 8'h67, 8'h5f, 8'h57, 8'h4f, 8'h47,
        8'h3f, 8'h37, 8'h2f, 8'h27, 8'h1f, 8'h17, 8'h0f, 8'h07,
        8'h00, 8'hf9, 8'hf1, 8'he9, 8'he1, 8'hd9, 8'hd1, 8'hc9,
        8'hc1, 8'hb9, 8'hb1, 8'ha9, 8'ha1, 8'h99, 8'h91, 8'h89,
        8'h81, 8'h89, 8'h91, 8'h99, 8'ha1, 8'ha9, 8'hb1, 8'hb9,
        8'hc1, 8'hc9, 8'hd1, 8'hd9, 8'he1, 8'he9, 8'hf1, 8'hf9
    };

    localparam logic [7:0] SINE_TBL [TABLE_LEN] = '{
        8'h00, 8'h0c, 8'h18, 8'h24, 8'h30, 8'h3b, 8'h46, 8'h50,
        8'h5a, 8'h62, 8'h69, 8'h70, 8'h75, 8'h79, 8'h7d, 8'h7e,
        8'h7f, 8'h7e, 8'h7d, 8'h79, 8'h75, 8'h70, 8'h69, 8'h62,
        8'h5a, 8'h50, 8'h46, 8'h3b, 8'h30, 8'h24, 8'h18, 8'h0c,
        8'h00, 8'hf3, 8'he7, 8'hdb, 8'hcf, 8'hc4, 8'hb9, 8'haf,
        8'ha5, 8'h9d, 8'h96, 8'h8f, 8'h8a, 8'h86, 8'h82, 8'h81,
        8'h80, 8'h81, 8'h82, 8'h86, 8'h8a, 8'h8f, 8'h96, 8'h9d,
        8'ha5, 8'haf, 8'hb9, 8'hc4, 8'hcf, 8'hdb, 8'he7, 8'hf3
    };

    localparam logic [7:0] SAW_TBL [TABLE_LEN] = '{
        8'h02, 8'h06, 8'h0a, 8'h0e, 8'h12, 8'h16, 8'h1a, 8'h1e,
        8'h22, 8'h26, 8'h2a, 8'h2e, 8'h32, 8'h36, 8'h3a, 8'h3e,
        8'h42, 8'h46, 8'h4a, 8'h4e, 8'h52, 8'h57, 8'h5b, 8'h5f,
        8'h63, 8'h67, 8'h6b, 8'h6f, 8'h73, 8'h77, 8'h7b, 8'h7f,
        8'h81, 8'h85, 8'h89, 8'h8d, 8'h91, 8'h95, 8'h99, 8'h9d,
        8'ha1, 8'ha5, 8'ha9, 8'hae, 8'hb2, 8'hb6, 8'hba, 8'hbe,
        8'hc2, 8'hc6, 8'hca, 8'hce, 8'hd2, 8'hd6, 8'hda, 8'hde,
        8'he2, 8'he6, 8'hea, 8'hee, 8'hf2, 8'hf6, 8'hfa, 8'hfe
    };

    // Square is high for the first half of the table, low for the second.
    function automatic logic [7:0] wave_lookup(input shape_t shape, input logic [POS_W-1:0] pos);
        logic [7:0] value;
        case (shape)
            SHAPE_SQUARE:   value = pos[POS_W-1] ? 8'h80 : 8'h7f;
            SHAPE_TRIANGLE: value = TRIANGLE_TBL[pos];
            SHAPE_SINE:     value = SINE_TBL[pos];
            default:        value = SAW_TBL[pos];
        endcase
        return value;
    endfunction

endpackage

FILE: rtl/core/table_tone_and_noise_generator.sv
// ----------------------------------------------------------------------------
// table_tone_and_noise_generator: table tone and LFSR noise sound generator
// Throughput: one transaction per cycle while the output is not stalled; the
// channel state update and the table lookup with volume multiply each sit in
// their own register stage.
// Reset: synchronous active-low aresetn clears all state but the result register, LFSR loads 0xACE1;
// the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module table_tone_and_noise_generator #(
    parameter int TABLE_DEPTH = 64,
    parameter int PHASE_SCALE = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ttng_pkg::in_t  s_item,
    output logic           m_valid,
    input  logic           m_ready,
    output ttng_pkg::out_t m_item
);
    import ttng_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int TACC_W = $clog2(PHASE_SCALE * 16 + 8);
    localparam int NACC_W = $clog2(PHASE_SCALE * 32 + 8);
    localparam logic [POS_W-1:0] STEP_Q = POS_W'(TABLE_LEN / TABLE_DEPTH);
    localparam logic [IDX_W:0]   STEP_R = (IDX_W + 1)'(TABLE_LEN % TABLE_DEPTH);
    localparam logic [IDX_W:0]   DEPTH_V = (IDX_W + 1)'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    // Architectural state
    logic [1:0]        enable_reg, enable_next;
    logic [1:0]        octave_reg, octave_next;
    logic [3:0]        shape_reg, shape_next;
    logic [3:0]        divider_reg, divider_next;
    logic [3:0]        volume_reg, volume_next;
    shape_t            lat_shape_reg, lat_shape_next;
    logic [1:0]        lat_octave_reg, lat_octave_next;
    logic [3:0]        lat_divider_reg, lat_divider_next;
    logic [TACC_W-1:0] tone_acc_reg, tone_acc_next;
    logic [IDX_W-1:0]  tone_idx_reg, tone_idx_next;
    logic [IDX_W-1:0]  tone_rem_reg, tone_rem_next;
    logic [POS_W-1:0]  tone_pos_reg, tone_pos_next;
    logic [NACC_W-1:0] noise_acc_reg, noise_acc_next;
    logic [15:0]       lfsr_reg, lfsr_next;
    logic [7:0]        noise_byte_reg, noise_byte_next;

    // Pipeline control and result
    logic busy_reg, busy_next;
    logic m_valid_reg, m_valid_next;
    out_t result_reg, result_next;

    logic s_fire, s1_advance;
    logic restart, tick;

    // Phase and index arithmetic
    logic [NACC_W-1:0] inc, thr, thr2;
    logic [NACC_W-1:0] tone_sum, noise_sum;
    logic              tone_hit, noise_hit;
    logic [IDX_W:0]    rem_sum;
    logic              rem_wrap;
    logic              idx_last;
    logic [15:0]       lfsr_step;

    // Output stage
    logic [7:0]         tone_raw;
    logic signed [4:0]  vol_s;
    logic signed [12:0] tone_prod, noise_prod;

    assign s1_advance = busy_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !busy_reg || s1_advance;
    assign s_fire     = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_item     = result_reg;

    assign inc       = NACC_W'(1) << lat_octave_reg;
    assign thr       = NACC_W'(PHASE_SCALE) * (NACC_W'(16) - NACC_W'(lat_divider_reg));
    assign thr2      = thr << 1;
    assign tone_sum  = NACC_W'(tone_acc_reg) + inc;
    assign noise_sum = noise_acc_reg + inc;
    assign tone_hit  = tone_sum >= thr;
    assign noise_hit = noise_sum >= thr2;

    // Table position tracks floor(index * 64 / depth) with a running remainder.
    assign rem_sum  = {1'b0, tone_rem_reg} + STEP_R;
    assign rem_wrap = rem_sum >= DEPTH_V;
    assign idx_last = tone_idx_reg == IDX_LAST;

    assign lfsr_step = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5], lfsr_reg[15:1]};

    always_comb begin
        enable_next      = enable_reg;
        octave_next      = octave_reg;
        shape_next       = shape_reg;
        divider_next     = divider_reg;
        volume_next      = volume_reg;
        lat_shape_next   = lat_shape_reg;
        lat_octave_next  = lat_octave_reg;
        lat_divider_next = lat_divider_reg;
        tone_acc_next    = tone_acc_reg;
        tone_idx_next    = tone_idx_reg;
        tone_rem_next    = tone_rem_reg;
        tone_pos_next    = tone_pos_reg;
        noise_acc_next   = noise_acc_reg;
        lfsr_next        = lfsr_reg;
        noise_byte_next  = noise_byte_reg;
        restart          = 1'b0;
        tick             = 1'b0;

        if (s_fire) begin
            unique case (s_item.mode)
                MODE_WR0: begin
                    octave_next = s_item.data[5:4];
                    shape_next  = s_item.data[3:0];
                    if (s_item.data[7:6] != enable_reg) begin
                        enable_next = s_item.data[7:6];
                        restart     = 1'b1;
                    end
                end
                MODE_WR1: begin
                    divider_next = s_item.data[7:4];
                    volume_next  = s_item.data[3:0];
                    restart      = 1'b1;
                end
                MODE_TICK: tick = 1'b1;
                default: ;
            endcase
        end

        // Restart: latch shape, octave and divider; rewind enabled channels, stepping the noise LFSR once.
        if (restart) begin
            lat_shape_next   = shape_t'(shape_next[3:2]);
            lat_octave_next  = octave_next;
            lat_divider_next = divider_next;
            if (enable_next[0]) begin
                tone_acc_next = '0;
                tone_idx_next = '0;
                tone_rem_next = '0;
                tone_pos_next = '0;
            end
            if (enable_next[1]) begin
                noise_acc_next  = '0;
                lfsr_next       = lfsr_step;
                noise_byte_next = lfsr_step[7:0];
            end
        end

        if (tick) begin
            if (enable_reg[0]) begin
                tone_acc_next = TACC_W'(tone_hit ? tone_sum - thr : tone_sum);
                if (tone_hit) begin
                    if (idx_last) begin
                        tone_idx_next = '0;
                        tone_rem_next = '0;
                        tone_pos_next = '0;
                    end else begin
                        tone_idx_next = tone_idx_reg + IDX_W'(1);
                        tone_rem_next = rem_wrap ? IDX_W'(rem_sum - DEPTH_V)
                                                 : rem_sum[IDX_W-1:0];
                        tone_pos_next = tone_pos_reg + STEP_Q + POS_W'(rem_wrap);
                    end
                end
            end
            if (enable_reg[1]) begin
                noise_acc_next = noise_hit ? noise_sum - thr2 : noise_sum;
                if (noise_hit) begin
                    lfsr_next       = lfsr_step;
                    noise_byte_next = lfsr_step[7:0];
                end
            end
        end
    end

    // Output stage reads the state left by the transaction in flight.
    assign tone_raw   = wave_lookup(lat_shape_reg, tone_pos_reg);
    assign vol_s      = $signed({1'b0, volume_reg});
    assign tone_prod  = $signed(tone_raw) * vol_s;
    assign noise_prod = $signed(noise_byte_reg) * vol_s;

    always_comb begin
        result_next.tone_sample  = enable_reg[0] ? $signed(tone_prod[SAMPLE_W-1:0]) : '0;
        result_next.noise_sample = enable_reg[1] ? $signed(noise_prod[SAMPLE_W-1:0]) : '0;
        result_next.tone_on      = enable_reg[0];
        result_next.noise_on     = enable_reg[1];
    end

    always_comb begin
        busy_next    = s_fire ? 1'b1 : (s1_advance ? 1'b0 : busy_reg);
        m_valid_next = s1_advance ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg      <= '0;
            octave_reg      <= '0;
            shape_reg       <= '0;
            divider_reg     <= '0;
            volume_reg      <= '0;
            lat_shape_reg   <= SHAPE_SQUARE;
            lat_octave_reg  <= '0;
            lat_divider_reg <= '0;
            tone_acc_reg    <= '0;
            tone_idx_reg    <= '0;
            tone_rem_reg    <= '0;
            tone_pos_reg    <= '0;
            noise_acc_reg   <= '0;
            lfsr_reg        <= 16'hACE1;
            noise_byte_reg  <= '0;
            busy_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            enable_reg      <= enable_next;
            octave_reg      <= octave_next;
            shape_reg       <= shape_next;
            divider_reg     <= divider_next;
            volume_reg      <= volume_next;
            lat_shape_reg   <= lat_shape_next;
            lat_octave_reg  <= lat_octave_next;
            lat_divider_reg <= lat_divider_next;
            tone_acc_reg    <= tone_acc_next;
            tone_idx_reg    <= tone_idx_next;
            tone_rem_reg    <= tone_rem_next;
            tone_pos_reg    <= tone_pos_next;
            noise_acc_reg   <= noise_acc_next;
            lfsr_reg        <= lfsr_next;
            noise_byte_reg  <= noise_byte_next;
            busy_reg        <= busy_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            result_reg <= result_next;
        end
    end

    // Phase accumulators stay below their wrap point while the channel runs.
    a_tone_acc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        enable_reg[0] |-> (NACC_W'(tone_acc_reg) < thr))
        else $error("tone accumulator at or above threshold");

    a_noise_acc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        enable_reg[1] |-> (noise_acc_reg < thr2))
        else $error("noise accumulator at or above threshold");

    a_pos_rewind: assert property (@(posedge aclk) disable iff (!aresetn)
        (tone_idx_reg == '0) |-> (tone_pos_reg == '0 && tone_rem_reg == '0))
        else $error("table position out of step with index");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("transaction accepted while result stalled");

    a_silent_when_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !result_reg.tone_on) |-> (result_reg.tone_sample == '0))
        else $error("disabled tone channel not silent");

endmodule

FILE: tb/sv/table_tone_and_noise_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_tone_and_noise_generator_tb: self-checking bench for the sound generator
// Drives register writes, ticks and unused-mode transactions through the input
// channel and scores every output sample against a cycle-free behavioral model
// of the tone and noise channels. Both channels idle in random bursts, and the
// output side is held off once for long enough to back up the input side.
// ----------------------------------------------------------------------------
module table_tone_and_noise_generator_tb;
    import ttng_pkg::*;

    localparam int TONE_STEPS     = 64;
    localparam int PHASE_SCALE    = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1560;

    localparam logic [7:0] TRI_WAVE [TONE_STEPS] = '{
        8'h00, 8'h07, 8'h0f, 8'h17, 8'h1f, 8'h27, 8'h2f, 8'h37,
        8'h3f, 8'h47, 8'h4f, 8'h57, 8'h5f, 8'h67, 8'h6f, 8'h77,
        8'h7f, 8'h77, 8'h6f, 8'h67, 8'h5f, 8'h57, 8'h4f, 8'h47,
        8'h3f, 8'h37, 8'h2f, 8'h27, 8'h1f, 8'h17, 8'h0f, 8'h07,
        8'h00, 8'hf9, 8'hf1, 8'he9, 8'he1, 8'hd9, 8'hd1, 8'hc9,
        8'hc1, 8'hb9, 8'hb1, 8'ha9, 8'ha1, 8'h99, 8'h91, 8'h89,
        8'h81, 8'h89, 8'h91, 8'h99, 8'ha1, 8'ha9, 8'hb1, 8'hb9,
        8'hc1, 8'hc9, 8'hd1, 8'hd9, 8'he1, 8'he9, 8'hf1, 8'hf9
    };
    localparam logic [7:0] SINE_WAVE [TONE_STEPS] = '{
        8'h00, 8'h0c, 8'h18, 8'h24, 8'h30, 8'h3b, 8'h46, 8'h50,
        8'h5a, 8'h62, 8'h69, 8'h70, 8'h75, 8'h79, 8'h7d, 8'h7e,
        8'h7f, 8'h7e, 8'h7d, 8'h79, 8'h75, 8'h70, 8'h69, 8'h62,
        8'h5a, 8'h50, 8'h46, 8'h3b, 8'h30, 8'h24, 8'h18, 8'h0c,
        8'h00, 8'hf3, 8'he7, 8'hdb, 8'hcf, 8'hc4, 8'hb9, 8'haf,
        8'ha5, 8'h9d, 8'h96, 8'h8f, 8'h8a, 8'h86, 8'h82, 8'h81,
        8'h80, 8'h81, 8'h82, 8'h86, 8'h8a, 8'h8f, 8'h96, 8'h9d,
        8'ha5, 8'haf, 8'hb9, 8'hc4, 8'hcf, 8'hdb, 8'he7, 8'hf3
    };
    localparam logic [7:0] SAW_WAVE [TONE_STEPS] = '{
        8'h02, 8'h06, 8'h0a, 8'h0e, 8'h12, 8'h16, 8'h1a, 8'h1e,
        8'h22, 8'h26, 8'h2a, 8'h2e, 8'h32, 8'h36, 8'h3a, 8'h3e,
        8'h42, 8'h46, 8'h4a, 8'h4e, 8'h52, 8'h57, 8'h5b, 8'h5f,
        8'h63, 8'h67, 8'h6b, 8'h6f, 8'h73, 8'h77, 8'h7b, 8'h7f,
        8'h81, 8'h85, 8'h89, 8'h8d, 8'h91, 8'h95, 8'h99, 8'h9d,
        8'ha1, 8'ha5, 8'ha9, 8'hae, 8'hb2, 8'hb6, 8'hba, 8'hbe,
        8'hc2, 8'hc6, 8'hca, 8'hce, 8'hd2, 8'hd6, 8'hda, 8'hde,
        8'he2, 8'he6, 8'hea, 8'hee, 8'hf2, 8'hf6, 8'hfa, 8'hfe
    };

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_item  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_item;

    // generator model state
    logic [1:0]  en_pair    = '0;
    logic [1:0]  oct_reg    = '0;
    logic [3:0]  shape_code = '0;
    logic [3:0]  div_reg    = '0;
    logic [3:0]  vol_reg    = '0;
    shape_t      cur_shape  = SHAPE_SQUARE;
    logic [1:0]  cur_oct    = '0;
    logic [3:0]  cur_div    = '0;
    int unsigned tone_acc   = 0;
    logic [5:0]  tone_pos   = '0;
    int unsigned noise_acc  = 0;
    logic [15:0] noise_lfsr = 16'hace1;
    logic [7:0]  noise_val  = '0;

    out_t pending_samples [$];
    int   items_sent   = 0;
    int   fail_count   = 0;
    int   quiet_cycles = 0;
    int   stall_left   = 0;
    int   holds_asked  = 0;
    int   holds_done   = 0;
    bit   idle_on      = 1'b1;

    table_tone_and_noise_generator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [7:0] tone_level(input shape_t shape, input logic [5:0] pos);
        case (shape)
            SHAPE_SQUARE:   return pos[5] ? 8'h80 : 8'h7f;
            SHAPE_TRIANGLE: return TRI_WAVE[pos];
            SHAPE_SINE:     return SINE_WAVE[pos];
            default:        return SAW_WAVE[pos];
        endcase
    endfunction

    function automatic logic signed [11:0] scale_sample(input logic [7:0] level,
                                                        input logic [3:0] vol);
        int prod;
        prod = int'($signed(level)) * int'(vol);
        return prod[11:0];
    endfunction

    function automatic void step_noise();
        logic fb;
        fb = noise_lfsr[0] ^ noise_lfsr[2] ^ noise_lfsr[3] ^ noise_lfsr[5];
        noise_lfsr = {fb, noise_lfsr[15:1]};
        noise_val = noise_lfsr[7:0];
    endfunction

    // latch the pending settings and rewind whichever channels are enabled
    function automatic void restart_channels();
        cur_shape = shape_t'(shape_code[3:2]);
        cur_oct = oct_reg;
        cur_div = div_reg;
        if (en_pair[0]) begin
            tone_acc = 0;
            tone_pos = '0;
        end
        if (en_pair[1]) begin
            noise_acc = 0;
            step_noise();
        end
    endfunction

    function automatic out_t predict_samples(input in_t txn);
        out_t        res;
        int unsigned inc;
        int unsigned span;
        case (txn.mode)
            MODE_WR0: begin
                oct_reg = txn.data[5:4];
                shape_code = txn.data[3:0];
                if (txn.data[7:6] != en_pair) begin
                    en_pair = txn.data[7:6];
                    restart_channels();
                end
            end
            MODE_WR1: begin
                div_reg = txn.data[7:4];
                vol_reg = txn.data[3:0];
                restart_channels();
            end
            MODE_TICK: begin
                inc = 1 << cur_oct;
                span = PHASE_SCALE * (16 - cur_div);
                if (en_pair[0]) begin
                    tone_acc += inc;
                    if (tone_acc >= span) begin
                        tone_acc -= span;
                        tone_pos++;
                    end
                end
                // noise advances at half the tone rate
                if (en_pair[1]) begin
                    noise_acc += inc;
                    if (noise_acc >= 2 * span) begin
                        noise_acc -= 2 * span;
                        step_noise();
                    end
                end
            end
            default: ;
        endcase
        res.tone_sample = en_pair[0] ? scale_sample(tone_level(cur_shape, tone_pos), vol_reg)
                                     : '0;
        res.noise_sample = en_pair[1] ? scale_sample(noise_val, vol_reg) : '0;
        res.tone_on = en_pair[0];
        res.noise_on = en_pair[1];
        return res;
    endfunction

    // entered and left at a falling edge
    task automatic play_item(input mode_t mode, input logic [7:0] data);
        in_t txn;
        txn.mode = mode;
        txn.data = data;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_item <= txn;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_samples.push_back(predict_samples(txn));
        items_sent++;
        @(negedge aclk);
    endtask

    // program each register with random content most of the time, then run the channels
    task automatic play_sequence(input int n_ticks);
        logic [1:0] pair;
        logic [3:0] div;
        pair = ($urandom_range(0, 9) == 0) ? 2'b00 : 2'($urandom_range(1, 3));
        div = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(12, 15)) : 4'($urandom);
        if ($urandom_range(0, 9) != 0)
            play_item(MODE_WR0, {pair, 6'($urandom)});
        if ($urandom_range(0, 9) != 0)
            play_item(MODE_WR1, {div, 4'($urandom)});
        repeat (n_ticks) begin
            if ($urandom_range(0, 19) == 0)
                play_item(mode_t'(2'($urandom_range(0, 3))), 8'($urandom));
            else
                play_item(MODE_TICK, 8'($urandom));
        end
    endtask

    task automatic test_idle_outputs();
        play_item(MODE_NOP, 8'hff);
        play_item(MODE_TICK, 8'h00);
    endtask

    task automatic test_register_writes();
        play_item(MODE_WR1, 8'hff);  // restart with both channels off
        play_item(MODE_WR0, 8'hff);  // enable change: restart both channels
        play_item(MODE_WR0, 8'hff);  // same enables: no restart
        play_item(MODE_TICK, 8'hff);
        play_item(MODE_WR0, 8'hc0);  // new shape and octave stay pending
        play_item(MODE_TICK, 8'h5a);
        play_item(MODE_WR1, 8'h00);  // slowest rate, zero volume
        play_item(MODE_WR1, 8'h0f);
        play_item(MODE_NOP, 8'h00);
        play_item(MODE_WR0, 8'h80);  // noise only
        play_item(MODE_WR0, 8'h00);  // both channels silenced
    endtask

    task automatic test_waveforms();
        for (int k = 0; k < 4; k++) begin
            play_item(MODE_WR0, {2'b01, 2'b11, 2'(k), 2'(k)});
            play_item(MODE_WR1, 8'hf7);
            play_item(MODE_TICK, 8'($urandom));
        end
    endtask

    task automatic test_output_stall();
        holds_asked++;
        play_sequence(80);
    endtask

    task automatic test_random_play();
        while (items_sent < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            play_sequence($urandom_range(20, 140));
        end
    endtask

    task automatic test_unthrottled_play();
        idle_on = 1'b0;
        repeat (2) play_sequence($urandom_range(60, 90));
    endtask

    // output side: random stall bursts, plus one long hold-off on request
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (holds_done < holds_asked) begin
            holds_done++;
            stall_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_samples.size() == 0) begin
                $error("unexpected output transaction: %p", m_item);
                fail_count++;
            end else begin
                want = pending_samples.pop_front();
                if (m_item.tone_sample !== want.tone_sample) begin
                    $error("tone_sample: expected %0d, got %0d",
                           want.tone_sample, m_item.tone_sample);
                    fail_count++;
                end
                if (m_item.noise_sample !== want.noise_sample) begin
                    $error("noise_sample: expected %0d, got %0d",
                           want.noise_sample, m_item.noise_sample);
                    fail_count++;
                end
                if (m_item.tone_on !== want.tone_on) begin
                    $error("tone_on: expected %0b, got %0b", want.tone_on, m_item.tone_on);
                    fail_count++;
                end
                if (m_item.noise_on !== want.noise_on) begin
                    $error("noise_on: expected %0b, got %0b", want.noise_on, m_item.noise_on);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("table_tone_and_noise_generator test failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_outputs();
        test_register_writes();
        test_waveforms();
        test_output_stall();
        test_random_play();
        test_unthrottled_play();

        s_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("table_tone_and_noise_generator test passed");
        else
            $display("table_tone_and_noise_generator test failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/ttng_pkg.sv
rtl/core/table_tone_and_noise_generator.sv
tb/sv/table_tone_and_noise_generator_tb.sv
